>>> hdl/sbc2u8_pkg.sv
package sbc2u8_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_code_point;
    typedef logic [1:0]  t_byte_count;

    // Largest code points for the one- and two-byte UTF-8 forms.
    localparam t_code_point CP_ONE_BYTE_MAX = 16'h007F;
    localparam t_code_point CP_TWO_BYTE_MAX = 16'h07FF;

    // Lead and continuation byte markers.
    localparam t_byte UTF8_LEAD2 = 8'hC0;
    localparam t_byte UTF8_LEAD3 = 8'hE0;
    localparam t_byte UTF8_CONT  = 8'h80;

    localparam t_byte_count COUNT_ONE   = 2'd1;
    localparam t_byte_count COUNT_TWO   = 2'd2;
    localparam t_byte_count COUNT_THREE = 2'd3;

    // Code points for the upper half of the character set, indexed by byte - 0x80.
    localparam t_code_point HIGH_MAP [128] = '{
        16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
        16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
        16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
        16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
        16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
        16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
        16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
        16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
        16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
        16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
        16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
        16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
        16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
        16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
        16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
        16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };

endpackage

>>> hdl/single_byte_charset_to_utf8_top.sv
// An accepted byte is registered in stages A, B and C; stage D then offers its first UTF-8 byte.
// One UTF-8 byte leaves per cycle while the receiver does not stall; the single-byte output
// port sets this rate. A character is 1 byte for ASCII, 2 for code points up to 0x7FF, 3 above.
// Input transactions are taken every cycle while the characters are ASCII and the output does
// not stall. Longer characters fill the three buffer stages, and the input then stalls.
// Reset (i_rst_n low, synchronous) empties every pipeline stage; no other state exists.
module single_byte_charset_to_utf8_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input channel: one legacy character byte per transaction.
    input  logic              i_valid,
    output logic              o_stall,
    input  sbc2u8_pkg::t_byte i_char_byte,
    input  logic              i_string_end,
    // Output channel: one UTF-8 byte per transaction.
    output logic              o_valid,
    input  logic              i_stall,
    output sbc2u8_pkg::t_byte o_utf8_byte,
    output logic              o_char_last,
    output logic              o_string_last
);
    import sbc2u8_pkg::*;

    // Stage A holds the accepted input byte.
    logic        r_a_valid;
    t_byte       r_a_byte;
    logic        r_a_end;

    // Stage B holds the code point after the table lookup.
    logic        r_b_valid;
    t_code_point r_b_cp;
    logic        r_b_end;
    t_code_point n_b_cp;

    // Stage C holds the encoded character: up to three bytes and their count.
    logic        r_c_valid;
    t_byte       r_c_bytes [3];
    t_byte_count r_c_cnt;
    logic        r_c_end;
    t_byte       n_c_bytes [3];
    t_byte_count n_c_cnt;

    // Stage D is the output serializer. The byte on the port is always entry 0;
    // the remaining bytes shift down as each output transaction completes.
    logic        r_d_valid;
    t_byte       r_d_bytes [3];
    t_byte_count r_d_rem;
    logic        r_d_end;

    // Handshake between stages. A stage may load when it is empty or when its
    // current contents move on in the same cycle, so nothing is lost or repeated.
    logic        d_take;
    logic        d_free;
    logic        c_ready;
    logic        b_ready;
    logic        a_ready;

    assign d_take  = r_d_valid && !i_stall;
    assign d_free  = !r_d_valid || (d_take && (r_d_rem == COUNT_ONE));
    assign c_ready = !r_c_valid || d_free;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;

    assign o_stall = !a_ready;

    // ASCII bytes are their own code point; the upper half goes through the table.
    always_comb begin
        if (r_a_byte[7]) begin
            n_b_cp = HIGH_MAP[r_a_byte[6:0]];
        end else begin
            n_b_cp = {8'h00, r_a_byte};
        end
    end

    // UTF-8 encoding of the code point in stage B. Unused byte slots are don't-care
    // but are driven to zero to keep the logic defined.
    always_comb begin
        n_c_bytes[0] = '0;
        n_c_bytes[1] = '0;
        n_c_bytes[2] = '0;
        if (r_b_cp <= CP_ONE_BYTE_MAX) begin
            n_c_bytes[0] = r_b_cp[7:0];
            n_c_cnt      = COUNT_ONE;
        end else if (r_b_cp <= CP_TWO_BYTE_MAX) begin
            n_c_bytes[0] = UTF8_LEAD2 | {3'b000, r_b_cp[10:6]};
            n_c_bytes[1] = UTF8_CONT  | {2'b00, r_b_cp[5:0]};
            n_c_cnt      = COUNT_TWO;
        end else begin
            n_c_bytes[0] = UTF8_LEAD3 | {4'h0, r_b_cp[15:12]};
            n_c_bytes[1] = UTF8_CONT  | {2'b00, r_b_cp[11:6]};
            n_c_bytes[2] = UTF8_CONT  | {2'b00, r_b_cp[5:0]};
            n_c_cnt      = COUNT_THREE;
        end
    end

    // Valid bits of every stage; these are the only registers that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
            if (d_free) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    // Payload registers travel with their valid bits and hold while stalled.
    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_byte <= i_char_byte;
            r_a_end  <= i_string_end;
        end
        if (b_ready) begin
            r_b_cp  <= n_b_cp;
            r_b_end <= r_a_end;
        end
        if (c_ready) begin
            r_c_bytes <= n_c_bytes;
            r_c_cnt   <= n_c_cnt;
            r_c_end   <= r_b_end;
        end
        if (d_free) begin
            r_d_bytes <= r_c_bytes;
            r_d_rem   <= r_c_cnt;
            r_d_end   <= r_c_end;
        end else if (d_take) begin
            // More bytes of this character remain: shift the next one to the port.
            r_d_bytes[0] <= r_d_bytes[1];
            r_d_bytes[1] <= r_d_bytes[2];
            r_d_rem      <= r_d_rem - COUNT_ONE;
        end
    end

    // The string-end mark appears only on the last byte of its character.
    assign o_valid       = r_d_valid;
    assign o_utf8_byte   = r_d_bytes[0];
    assign o_char_last   = (r_d_rem == COUNT_ONE);
    assign o_string_last = r_d_end && (r_d_rem == COUNT_ONE);

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import sbc2u8_pkg::*;

    // One UTF-8 output transaction as the scoreboard expects it.
    typedef struct packed {
        t_byte utf8;
        logic  char_last;
        logic  string_last;
    } t_utf8_out;

    // Code points for bytes 0x80 to 0xFF of the Roman character set. This is kept
    // apart from the table in the package so that a wrong entry there shows up.
    localparam logic [15:0] ROMAN_HIGH_CP [128] = '{
        16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
        16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
        16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
        16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
        16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
        16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
        16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
        16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
        16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
        16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
        16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
        16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
        16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
        16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
        16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
        16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
    };

    // Scoreboard: encodes each accepted character into the UTF-8 bytes it should
    // produce and compares the output transactions with them, oldest first.
    class utf8_scoreboard;
        t_utf8_out expected_bytes[$];
        int        errors;
        int        ascii_chars;
        int        two_byte_chars;
        int        three_byte_chars;
        int        strings_ended;
        int        bytes_checked;

        function new();
            errors           = 0;
            ascii_chars      = 0;
            two_byte_chars   = 0;
            three_byte_chars = 0;
            strings_ended    = 0;
            bytes_checked    = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        task report(input string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        // Appends one expected output transaction at the tail of the queue.
        function void add_expected(input t_byte utf8, input logic char_last,
                                   input logic string_last);
            t_utf8_out entry;
            entry.utf8        = utf8;
            entry.char_last   = char_last;
            entry.string_last = string_last;
            expected_bytes.insert(expected_bytes.size(), entry);
        endfunction

        // Called once per accepted input transaction.
        function void note_char(input t_byte char_byte, input logic string_end);
            logic [15:0] cp;
            if (string_end) begin
                strings_ended++;
            end
            if (char_byte < 8'h80) begin
                // Plain ASCII goes through as a single byte.
                add_expected(char_byte, 1'b1, string_end);
                ascii_chars++;
            end else begin
                cp = ROMAN_HIGH_CP[char_byte[6:0]];
                if (cp <= CP_TWO_BYTE_MAX) begin
                    add_expected(UTF8_LEAD2 | {3'b000, cp[10:6]}, 1'b0, 1'b0);
                    add_expected(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, string_end);
                    two_byte_chars++;
                end else begin
                    add_expected(UTF8_LEAD3 | {4'b0000, cp[15:12]}, 1'b0, 1'b0);
                    add_expected(UTF8_CONT | {2'b00, cp[11:6]}, 1'b0, 1'b0);
                    add_expected(UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, string_end);
                    three_byte_chars++;
                end
            end
        endfunction

        // Called once per accepted output transaction.
        task check_byte(input t_byte utf8, input logic char_last, input logic string_last);
            t_utf8_out want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected output byte %02h", utf8));
            end else begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (utf8 !== want.utf8) begin
                    report($sformatf("utf8_byte %02h, want %02h", utf8, want.utf8));
                end
                if (char_last !== want.char_last) begin
                    report($sformatf("char_last %b, want %b (byte %02h)",
                                     char_last, want.char_last, want.utf8));
                end
                if (string_last !== want.string_last) begin
                    report($sformatf("string_last %b, want %b (byte %02h)",
                                     string_last, want.string_last, want.utf8));
                end
            end
        endtask
    endclass

    // Directed characters: the ASCII extremes, both ends of the high half, the
    // largest code points, lead bytes of every length and alternating bit patterns.
    localparam int N_DIRECTED = 18;
    localparam t_byte DIRECTED_CHARS [N_DIRECTED] = '{
        8'h00, 8'h7F, 8'h80, 8'hFF, 8'hA0, 8'hF0, 8'hDF, 8'hD7, 8'h55,
        8'hAA, 8'hC9, 8'h41, 8'hCA, 8'hBD, 8'hF5, 8'h81, 8'hFE, 8'h20
    };
    localparam logic [N_DIRECTED-1:0] DIRECTED_ENDS = 18'b10_1010_0110_0101_1010;

    localparam int ITEMS_PER_PHASE = 70;
    localparam int SETTLE_CYCLES   = 10;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_stall;
    t_byte i_char_byte = '0;
    logic  i_string_end = 1'b0;
    logic  o_valid;
    logic  i_stall = 1'b0;
    t_byte o_utf8_byte;
    logic  o_char_last;
    logic  o_string_last;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;

    utf8_scoreboard sb = new();

    single_byte_charset_to_utf8_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_byte   (i_char_byte),
        .i_string_end  (i_string_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_utf8_byte   (o_utf8_byte),
        .o_char_last   (o_char_last),
        .o_string_last (o_string_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The receiver decides its stall afresh at every rising edge.
    always @(posedge i_clk) begin
        i_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Outputs are sampled mid-cycle, where everything driven at the rising edge has
    // settled. A byte offered while the receiver is not stalling is taken at the next
    // rising edge, so it is checked here.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_byte(o_utf8_byte, o_char_last, o_string_last);
        end
    end

    // Offers one character byte and returns at the rising edge where the transaction
    // is taken. It is called, and returns, right after a rising edge.
    task automatic send_char(input t_byte char_byte, input logic string_end);
        bit taken;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_char_byte  <= char_byte;
        i_string_end <= string_end;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            if (taken) begin
                sb.note_char(char_byte, string_end);
            end
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // The sender goes quiet until every expected byte has come out.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random character: ASCII or the high half in roughly equal share, with each
    // half drawn uniformly so that every table entry gets its turn.
    function automatic t_byte random_char();
        if ($urandom_range(1) == 0) begin
            return t_byte'($urandom_range(8'h7F));
        end
        return t_byte'($urandom_range(8'hFF, 8'h80));
    endfunction

    // Strings of random length end with the end mark on their last character.
    // One string in eight may carry stray end marks in its middle as well.
    task automatic send_random_strings(input int count);
        int len;
        bit noisy;
        int sent;
        sent = 0;
        while (sent < count) begin
            len   = $urandom_range(12, 1);
            noisy = ($urandom_range(7) == 0);
            for (int k = 0; k < len; k++) begin
                send_char(random_char(),
                          (k == len - 1) || (noisy && $urandom_range(3) == 0));
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed characters go in back to back with no idling on either side.
        for (int k = 0; k < N_DIRECTED; k++) begin
            send_char(DIRECTED_CHARS[k], DIRECTED_ENDS[k]);
        end
        wait_for_drain();

        // Random strings under each idling pattern. Between phases the sender holds
        // off until the output has drained completely.
        send_random_strings(ITEMS_PER_PHASE);
        wait_for_drain();

        send_idle_pct = 45;
        send_random_strings(ITEMS_PER_PHASE);
        wait_for_drain();

        send_idle_pct  = 0;
        recv_stall_pct = 45;
        send_random_strings(ITEMS_PER_PHASE);
        wait_for_drain();

        send_idle_pct  = 18;
        recv_stall_pct = 18;
        send_random_strings(ITEMS_PER_PHASE);
        wait_for_drain();

        // A final wait catches any byte the block emits beyond the expected ones.
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d characters in %0d strings: %0d ASCII, %0d two-byte, %0d three-byte.",
                 items_sent, sb.strings_ended, sb.ascii_chars, sb.two_byte_chars,
                 sb.three_byte_chars);
        $display("Checked %0d UTF-8 bytes under four idle and stall patterns; %0d mismatches.",
                 sb.bytes_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of about 320 characters.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
